// ===== rtl/waypoint_heading_speed_controller_assert.svh =====
// Assertion macros for the waypoint controller
`ifndef WAYPOINT_HEADING_SPEED_CONTROLLER_ASSERT_SVH
`define WAYPOINT_HEADING_SPEED_CONTROLLER_ASSERT_SVH
`define WHSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define WHSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/whsc_pkg.sv =====
// Shared types and constants for the waypoint controller
package whsc_pkg;
   localparam int ATAN_DEPTH = 24;
   localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
   localparam logic [31:0] PI_Q29 = 32'd1686629713;
   localparam logic [2:0] CSR_MAX_SPEED = 3'd0;
   localparam logic [2:0] CSR_SLOW_RAD = 3'd1;
   localparam logic [2:0] CSR_ARRIVE_RAD = 3'd2;
   localparam logic [2:0] CSR_DECAY = 3'd3;
   localparam logic [2:0] CSR_GAIN = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic cordic_step;
      logic sqrt_step;
      logic bear_mul;
      logic ang_mul;
      logic lin_mul;
      logic decay_mul;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic cordic_done;
      logic sqrt_done;
   } sts_type;
endpackage

// ===== rtl/whsc_ctrl.sv =====
// Sequencing state machine for the waypoint controller
module whsc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  whsc_pkg::sts_type  sts,
   output whsc_pkg::cmd_type  cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ITER = 3'd1;
   localparam logic [2:0] ST_BEAR = 3'd2;
   localparam logic [2:0] ST_ANG = 3'd3;
   localparam logic [2:0] ST_LIN = 3'd4;
   localparam logic [2:0] ST_DECAY = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            cmd.cordic_step = !sts.cordic_done;
            cmd.sqrt_step = !sts.sqrt_done;
            if (sts.cordic_done && sts.sqrt_done) state_in = ST_BEAR;
         end
         ST_BEAR: begin
            cmd.bear_mul = 1'b1;
            state_in = ST_ANG;
         end
         ST_ANG: begin
            cmd.ang_mul = 1'b1;
            state_in = ST_LIN;
         end
         ST_LIN: begin
            cmd.lin_mul = 1'b1;
            state_in = ST_DECAY;
         end
         ST_DECAY: begin
            cmd.decay_mul = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `include "waypoint_heading_speed_controller_assert.svh"
   `WHSC_ASSERT_IMP(a_load_idle, clock, reset, cmd.load, state_ff == ST_IDLE)
   `WHSC_ASSERT_NXT(a_finish_valid, clock, reset, cmd.finish, rsp_valid_ff)
   `WHSC_ASSERT_IMP(a_busy_stall, clock, reset, state_ff != ST_IDLE, req_stall)
endmodule

// ===== rtl/whsc_datapath.sv =====
// CORDIC, square root and scaling datapath of the waypoint controller
module whsc_datapath #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  whsc_pkg::cmd_type  cmd,
   output whsc_pkg::sts_type  sts,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [22:0]        csr_data,
   input  logic signed [23:0] req_robot_x,
   input  logic signed [23:0] req_robot_y,
   input  logic signed [15:0] req_heading,
   input  logic signed [23:0] req_target_x,
   input  logic signed [23:0] req_target_y,
   input  logic               req_turn_only,
   output logic [17:0]        rsp_linear_speed,
   output logic signed [20:0] rsp_angular_rate,
   output logic               rsp_waypoint_reached
);
   localparam int NSTEP = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int SH = 60 - FRAC_BITS;
   localparam int SQ_ITERS = 25;
   // ceil(2^37 / 100): exact quotient by 100 for any operand below 2^32
   localparam logic [30:0] RECIP_100 = 31'd1374389535;

   logic [17:0] max_speed_ff;
   logic [22:0] slow_rad_ff, arrive_rad_ff;
   logic [6:0]  decay_ff;
   logic [18:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= 18'd39322;
         slow_rad_ff <= 23'd65536;
         arrive_rad_ff <= 23'd19661;
         decay_ff <= 7'd40;
         gain_ff <= 19'd65536;
      end else if (csr_write) begin
         case (csr_index)
            whsc_pkg::CSR_MAX_SPEED: max_speed_ff <= csr_data[17:0];
            whsc_pkg::CSR_SLOW_RAD: slow_rad_ff <= csr_data;
            whsc_pkg::CSR_ARRIVE_RAD: arrive_rad_ff <= csr_data;
            whsc_pkg::CSR_DECAY: decay_ff <= csr_data[6:0];
            whsc_pkg::CSR_GAIN: gain_ff <= csr_data[18:0];
            default: ;
         endcase
      end
   end

   // offset is 25 bits; CORDIC grows by < 1.65, keep 28 bits
   logic signed [27:0] cx_ff, cy_ff, cx_in, cy_in;
   logic [31:0] cz_ff, cz_in;
   logic [4:0] ci_ff;
   logic [15:0] hd_ff;
   logic zero_ff, turn_ff;
   logic [49:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   logic [4:0] si_ff;
   logic signed [24:0] dx, dy;
   logic [24:0] adx, ady;
   logic [49:0] sq_sum;

   assign dx = 25'(req_target_x) - 25'(req_robot_x);
   assign dy = 25'(req_target_y) - 25'(req_robot_y);
   assign adx = dx[24] ? 25'(-dx) : dx;
   assign ady = dy[24] ? 25'(-dy) : dy;
   assign sq_sum = 50'(adx) * 50'(adx) + 50'(ady) * 50'(ady);

   // restoring square root, one result bit per step
   logic [51:0] trial;
   logic [4:0] sbit;
   assign sbit = 5'(SQ_ITERS - 1) - si_ff;
   assign trial = {2'b0, rem_ff} - ({27'b0, root_ff} << (sbit + 1)
                  | (52'd1 << (2 * sbit)));

   always_comb begin
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      if (cy_ff > 0) begin
         cx_in = cx_ff + (cy_ff >>> ci_ff);
         cy_in = cy_ff - (cx_ff >>> ci_ff);
         cz_in = cz_ff + whsc_pkg::ATAN_TAB[ci_ff];
      end else begin
         cx_in = cx_ff - (cy_ff >>> ci_ff);
         cy_in = cy_ff + (cx_ff >>> ci_ff);
         cz_in = cz_ff - whsc_pkg::ATAN_TAB[ci_ff];
      end
      rem_in = rem_ff; root_in = root_ff;
      if (!trial[51]) begin
         rem_in = trial[49:0];
         root_in = root_ff | (25'd1 << sbit);
      end
   end

   assign sts.cordic_done = (ci_ff == 5'(NSTEP));
   assign sts.sqrt_done = (si_ff == 5'(SQ_ITERS));

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff <= 5'(NSTEP);
         si_ff <= 5'(SQ_ITERS);
      end else if (cmd.load) begin
         ci_ff <= '0;
         si_ff <= '0;
      end else begin
         if (cmd.cordic_step) ci_ff <= ci_ff + 5'd1;
         if (cmd.sqrt_step) si_ff <= si_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff <= dx[24] ? -28'(dx) : 28'(dx);
         cy_ff <= dx[24] ? -28'(dy) : 28'(dy);
         cz_ff <= dx[24] ? 32'h80000000 : 32'h0;
         hd_ff <= req_heading;
         zero_ff <= (dx == 0) && (dy == 0);
         turn_ff <= req_turn_only;
         rem_ff <= sq_sum;
         root_ff <= '0;
      end else begin
         if (cmd.cordic_step) begin
            cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
         end
         if (cmd.sqrt_step) begin
            rem_ff <= rem_in; root_ff <= root_in;
         end
      end
   end

   // scaling stages
   logic [31:0] d_ang;
   logic [31:0] mag;
   logic [63:0] bprod;
   logic signed [32:0] bear_ff;
   logic signed [53:0] gprod;
   logic [53:0] gmag;
   logic signed [21:0] ang_ff;
   logic [42:0] lprod;
   logic [17:0] lin_ff;
   logic signed [20:0] last_ff;
   logic signed [28:0] dq;
   logic signed [28:0] dqa;
   logic [26:0] dqa_ff;
   logic dneg_ff;
   logic [57:0] qprod;
   logic [26:0] quo;
   logic signed [21:0] red;
   logic [6:0] pc;
   logic reach;
   logic signed [20:0] ang_sat;

   assign d_ang = cz_ff - {hd_ff, 16'h0};
   assign mag = d_ang[31] ? 32'(-d_ang) : d_ang;
   assign bprod = 64'(mag) * 64'(whsc_pkg::PI_Q29) + (64'd1 << (SH - 1));
   always_ff @(posedge clock) begin
      if (cmd.bear_mul) begin
         if (zero_ff) bear_ff <= '0;
         else bear_ff <= d_ang[31] ? -33'(bprod >> SH) : 33'(bprod >> SH);
      end
   end

   assign gprod = $signed({1'b0, gain_ff}) * bear_ff;
   assign gmag = gprod[53] ? 54'(-gprod) : gprod;
   always_ff @(posedge clock) begin
      if (cmd.ang_mul) begin
         if ((gmag >> FRAC_BITS) > 54'd1048575)
            ang_ff <= gprod[53] ? -22'sd1048576 : 22'sd1048575;
         else
            ang_ff <= gprod[53] ? -22'(gmag >> FRAC_BITS) : 22'(gmag >> FRAC_BITS);
      end
   end

   assign lprod = 43'(max_speed_ff) * 43'(root_ff);
   always_ff @(posedge clock) begin
      if (cmd.lin_mul) begin
         if ({1'b0, root_ff} >= {3'b0, slow_rad_ff}) lin_ff <= max_speed_ff;
         else if ((lprod >> FRAC_BITS) > 43'd262143) lin_ff <= 18'h3FFFF;
         else lin_ff <= 18'(lprod >> FRAC_BITS);
      end
   end

   // last_ff holds still during an item, so the product is taken early
   assign pc = (decay_ff > 7'd100) ? 7'd100 : decay_ff;
   assign dq = 29'(last_ff) * $signed({1'b0, pc});
   assign dqa = dq[28] ? -dq : dq;
   always_ff @(posedge clock) begin
      if (cmd.ang_mul) begin
         dqa_ff <= 27'(dqa);
         dneg_ff <= dq[28];
      end
   end

   assign qprod = 58'(dqa_ff) * 58'(RECIP_100);
   assign quo = 27'(qprod >> 37);
   assign red = dneg_ff ? -22'(quo) : 22'(quo);
   assign reach = {1'b0, root_ff} < {3'b0, arrive_rad_ff};
   assign ang_sat = 21'(ang_ff);
   logic signed [20:0] dec_ff;
   always_ff @(posedge clock) begin
      if (cmd.decay_mul) dec_ff <= 21'(22'(last_ff) - red);
   end

   always_ff @(posedge clock) begin
      if (reset) last_ff <= '0;
      else if (cmd.finish && !turn_ff) last_ff <= reach ? dec_ff : ang_sat;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_linear_speed <= turn_ff ? 18'd0 : lin_ff;
         rsp_angular_rate <= (!turn_ff && reach) ? dec_ff : ang_sat;
         rsp_waypoint_reached <= !turn_ff && reach;
      end
   end

   `include "waypoint_heading_speed_controller_assert.svh"
   `WHSC_ASSERT_IMP(a_step_excl, clock, reset, cmd.load, !cmd.cordic_step && !cmd.sqrt_step)
   `WHSC_ASSERT_NXT(a_load_cnt, clock, reset, cmd.load, ci_ff == 5'd0 && si_ff == 5'd0)
   `WHSC_ASSERT_IMP(a_ang_fit, clock, reset, cmd.finish, ang_ff == 22'(ang_sat))
endmodule

// ===== rtl/waypoint_heading_speed_controller.sv =====
// Top level of the waypoint heading and speed controller
// Usage:
//  Request channel (req_*): robot x/y, heading, target x/y and turn_only.
//  An item is taken when req_valid is high and req_stall low.
//  Response channel (rsp_*): linear speed, angular rate, waypoint_reached,
//  one response per request, held while rsp_stall is high.
//  From accept to rsp_valid: the vectoring CORDIC and the bit-serial
//  square root run side by side (one result bit per cycle), then the
//  controller leaves the loop, four multiply stages follow and the
//  response is registered.
//  One item at a time: the next item is taken at the edge that takes
//  the response.
//  While a finished response is held by rsp_stall, req_stall stays high.
//  Reset (synchronous) restores all configuration registers to their
//  defaults and clears the remembered angular rate.
//  csr_write/csr_index/csr_data write configuration while idle.
module waypoint_heading_speed_controller #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [22:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_robot_x,
   input  logic signed [23:0] req_robot_y,
   input  logic signed [15:0] req_heading,
   input  logic signed [23:0] req_target_x,
   input  logic signed [23:0] req_target_y,
   input  logic               req_turn_only,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [17:0]        rsp_linear_speed,
   output logic signed [20:0] rsp_angular_rate,
   output logic               rsp_waypoint_reached
);
   whsc_pkg::cmd_type cmd;
   whsc_pkg::sts_type sts;

   whsc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd));

   whsc_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_robot_x(req_robot_x), .req_robot_y(req_robot_y),
      .req_heading(req_heading), .req_target_x(req_target_x),
      .req_target_y(req_target_y), .req_turn_only(req_turn_only),
      .rsp_linear_speed(rsp_linear_speed), .rsp_angular_rate(rsp_angular_rate),
      .rsp_waypoint_reached(rsp_waypoint_reached));
endmodule
